@@ rtl/tgfw_pkg.sv @@
// shared types, codes and the glyph table of the text glyph frame writer
`timescale 1ns / 1ps
`default_nettype none
package tgfw_pkg;

  localparam int DISPLAY_WIDTH_DEF = 128;
  localparam int PAGE_COUNT_DEF    = 8;
  localparam int QUEUE_DEPTH       = 2;
  localparam int GLYPH_COLS        = 5;
  localparam int CHAR_PITCH        = 6;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [7:0] CHAR_END     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [5:0] GLYPH_DIGIT0  = 6'd0;
  localparam logic [5:0] GLYPH_LETTERA = 6'd10;
  localparam logic [5:0] GLYPH_SPACE   = 6'd36;
  localparam logic [5:0] GLYPH_COLON   = 6'd37;
  localparam logic [5:0] GLYPH_DASH    = 6'd38;
  localparam logic [5:0] GLYPH_DOT     = 6'd39;
  localparam logic [5:0] GLYPH_PERCENT = 6'd40;
  localparam logic [5:0] GLYPH_SLASH   = 6'd41;
  localparam logic [5:0] GLYPH_UNKNOWN = 6'd42;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] glyph;
    logic       in_range;
    logic [7:0] column_now;
    logic [2:0] page_now;
  } cmd_t;

  function automatic logic [7:0] glyph_byte(input logic [5:0] g, input logic [2:0] c);
    logic [39:0] row;
    logic [7:0]  b;
    case (g)
      6'd0:  row = 40'h3E5149453E;
      6'd1:  row = 40'h00427F4000;
      6'd2:  row = 40'h6251494946;
      6'd3:  row = 40'h2249494936;
      6'd4:  row = 40'h1814127F10;
      6'd5:  row = 40'h2F49494931;
      6'd6:  row = 40'h3E49494932;
      6'd7:  row = 40'h0171090503;
      6'd8:  row = 40'h3649494936;
      6'd9:  row = 40'h264949493E;
      6'd10: row = 40'h7E1111117E;
      6'd11: row = 40'h7F49494936;
      6'd12: row = 40'h3E41414122;
      6'd13: row = 40'h7F4141221C;
      6'd14: row = 40'h7F49494941;
      6'd15: row = 40'h7F09090901;
      6'd16: row = 40'h3E4149497A;
      6'd17: row = 40'h7F0808087F;
      6'd18: row = 40'h00417F4100;
      6'd19: row = 40'h2040413F01;
      6'd20: row = 40'h7F08142241;
      6'd21: row = 40'h7F40404040;
      6'd22: row = 40'h7F0204027F;
      6'd23: row = 40'h7F0408107F;
      6'd24: row = 40'h3E4141413E;
      6'd25: row = 40'h7F09090906;
      6'd26: row = 40'h3E4151215E;
      6'd27: row = 40'h7F09192946;
      6'd28: row = 40'h4649494931;
      6'd29: row = 40'h01017F0101;
      6'd30: row = 40'h3F4040403F;
      6'd31: row = 40'h1F2040201F;
      6'd32: row = 40'h3F4038403F;
      6'd33: row = 40'h6314081463;
      6'd34: row = 40'h0708700807;
      6'd35: row = 40'h6151494543;
      GLYPH_SPACE:   row = 40'h0000000000;
      GLYPH_COLON:   row = 40'h0036000000;
      GLYPH_DASH:    row = 40'h0000080000;
      GLYPH_DOT:     row = 40'h0000400000;
      GLYPH_PERCENT: row = 40'h6313086400;
      GLYPH_SLASH:   row = 40'h2010080402;
      default:       row = 40'h0201510906;
    endcase
    case (c)
      3'd0:    b = row[39:32];
      3'd1:    b = row[31:24];
      3'd2:    b = row[23:16];
      3'd3:    b = row[15:8];
      3'd4:    b = row[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tgfw_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tgfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ rtl/tgfw_queue.sv @@
// short command queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module tgfw_queue
  import tgfw_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] PTR_LAST = PTRW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign pop_data = slots[rd_ptr];
  assign empty    = (count == '0);
  assign full     = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTRW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/tgfw_front.sv @@
// front part: cursor tracking, character classification and command build
`timescale 1ns / 1ps
`default_nettype none
module tgfw_front
  import tgfw_pkg::*;
#(
  parameter int DISPLAY_WIDTH = DISPLAY_WIDTH_DEF,
  parameter int PAGE_COUNT    = PAGE_COUNT_DEF
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         accept,
  input  wire logic [1:0]                                   op,
  input  wire logic [7:0]                                   char_code,
  input  wire logic [7:0]                                   cursor_column_in,
  input  wire logic [7:0]                                   cursor_page_in,
  input  wire logic [9:0]                                   read_address,
  output cmd_t                                              cmd,
  output logic      [$clog2(DISPLAY_WIDTH*PAGE_COUNT)-1:0]  addr
);

  localparam int CW = $clog2(DISPLAY_WIDTH + 1);
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int AW = $clog2(DISPLAY_WIDTH * PAGE_COUNT);
  localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int WRAP_LIMIT = DISPLAY_WIDTH - CHAR_PITCH;
  localparam logic [AW-1:0] WIDTH_A = AW'(DISPLAY_WIDTH);

  logic [CW-1:0] column;
  logic [PW-1:0] page;
  logic [CW-1:0] column_next;
  logic [PW-1:0] page_next;
  logic [PW-1:0] page_inc;
  logic [CW-1:0] wcol;
  logic [PW-1:0] wpage;
  logic [7:0]    folded;
  logic [5:0]    glyph;

  always_comb begin
    page_inc = (32'(page) + 1 < PAGE_COUNT) ? page + PW'(1) : '0;
    if (32'(column) > WRAP_LIMIT) begin
      wcol  = '0;
      wpage = page_inc;
    end else begin
      wcol  = column;
      wpage = page;
    end
  end

  always_comb begin
    folded = char_code;
    if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      folded = char_code - CASE_OFFSET;
    end
    if (folded == CHAR_SPACE) begin
      glyph = GLYPH_SPACE;
    end else if (folded >= CHAR_ZERO && folded <= CHAR_NINE) begin
      glyph = GLYPH_DIGIT0 + 6'(folded - CHAR_ZERO);
    end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
      glyph = GLYPH_LETTERA + 6'(folded - CHAR_UPPER_A);
    end else if (folded == CHAR_COLON) begin
      glyph = GLYPH_COLON;
    end else if (folded == CHAR_DASH) begin
      glyph = GLYPH_DASH;
    end else if (folded == CHAR_DOT) begin
      glyph = GLYPH_DOT;
    end else if (folded == CHAR_PERCENT) begin
      glyph = GLYPH_PERCENT;
    end else if (folded == CHAR_SLASH) begin
      glyph = GLYPH_SLASH;
    end else begin
      glyph = GLYPH_UNKNOWN;
    end
  end

  always_comb begin
    column_next  = column;
    page_next    = page;
    cmd.kind     = KIND_NONE;
    cmd.glyph    = glyph;
    cmd.in_range = 1'b0;
    addr         = '0;
    case (op)
      OP_CHAR: begin
        if (char_code == CHAR_NEWLINE) begin
          column_next = '0;
          page_next   = page_inc;
        end else if (char_code != CHAR_END) begin
          cmd.kind    = KIND_WRITE;
          addr        = AW'(AW'(wpage) * WIDTH_A + AW'(wcol));
          column_next = wcol + CW'(CHAR_PITCH);
          page_next   = wpage;
        end
      end
      OP_SET: begin
        column_next = (32'(cursor_column_in) < DISPLAY_WIDTH) ? CW'(cursor_column_in) : '0;
        page_next   = (32'(cursor_page_in) < PAGE_COUNT) ? PW'(cursor_page_in) : '0;
      end
      OP_CLEAR: begin
        cmd.kind    = KIND_CLEAR;
        column_next = '0;
        page_next   = '0;
      end
      OP_READ: begin
        cmd.kind     = KIND_READ;
        cmd.in_range = (32'(read_address) < STORE_SIZE);
        addr         = AW'(read_address);
      end
      default: begin
        cmd.kind = KIND_NONE;
      end
    endcase
    cmd.column_now = 8'(column_next);
    cmd.page_now   = 3'(page_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      page   <= '0;
    end else if (accept) begin
      column <= column_next;
      page   <= page_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tgfw_back.sv @@
// back part: frame store, glyph writes, clear sweeps, reads and results
`timescale 1ns / 1ps
`default_nettype none
module tgfw_back
  import tgfw_pkg::*;
#(
  parameter int DISPLAY_WIDTH = DISPLAY_WIDTH_DEF,
  parameter int PAGE_COUNT    = PAGE_COUNT_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        q_empty,
  input  cmd_t                                             q_cmd,
  input  wire logic [$clog2(DISPLAY_WIDTH*PAGE_COUNT)-1:0] q_addr,
  output logic                                             q_pop,
  output logic                                             init_busy,
  output logic                                             done,
  output logic      [7:0]                                  read_data,
  output logic      [7:0]                                  column_now,
  output logic      [2:0]                                  page_now
);

  localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW = $clog2(STORE_SIZE);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(STORE_SIZE - 1);
  localparam logic [2:0]    COL_LAST   = 3'(GLYPH_COLS - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0]    state;
  cmd_t          cur;
  logic [AW-1:0] cur_addr;
  logic [2:0]    cnt;
  logic [AW-1:0] sweep;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign init_busy = (state == S_INIT);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = q_addr;
    ram_wdata = 8'h00;
    case (state)
      S_INIT, S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = sweep;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = cur_addr + AW'(cnt);
        ram_wdata = glyph_byte(cur.glyph, cnt);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tgfw_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_cmd;
      cur_addr <= q_addr;
    end
    case (state)
      S_IDLE: begin
        read_data  <= 8'h00;
        column_now <= q_cmd.column_now;
        page_now   <= q_cmd.page_now;
      end
      S_WRITE, S_CLEAR: begin
        read_data  <= 8'h00;
        column_now <= cur.column_now;
        page_now   <= cur.page_now;
      end
      S_READ: begin
        read_data  <= cur.in_range ? ram_rdata : 8'h00;
        column_now <= cur.column_now;
        page_now   <= cur.page_now;
      end
      default: begin
        read_data <= 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          sweep <= sweep + AW'(1);
          if (sweep == SWEEP_LAST) begin
            sweep <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            cnt   <= '0;
            sweep <= '0;
            case (q_cmd.kind)
              KIND_WRITE: state <= S_WRITE;
              KIND_CLEAR: state <= S_CLEAR;
              KIND_READ:  state <= S_READ;
              default:    done  <= 1'b1;
            endcase
          end
        end
        S_WRITE: begin
          cnt <= cnt + 3'd1;
          if (cnt == COL_LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == SWEEP_LAST) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_write_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> cnt <= COL_LAST)
    else $error("glyph column count ran past the last column");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |=> !done)
    else $error("result beat during the power-up store sweep");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> done && state == S_IDLE)
    else $error("read did not return its beat in the next cycle");

endmodule
`default_nettype wire

@@ rtl/text_glyph_frame_writer.sv @@
// top level of the text glyph frame writer
`timescale 1ns / 1ps
`default_nettype none
// Text engine over a DISPLAY_WIDTH x PAGE_COUNT page-organized monochrome frame store
// (one byte per column per page, LSB on top). An item is taken when start is high and
// busy is low; each item gives exactly one result beat, shown for a single cycle with
// done high, in item order, and the receiver cannot stall it. Items pass through a
// two-entry queue to the store unit, which owns the single-port store: a character
// writes its 5 glyph bytes, a clear sweeps all DISPLAY_WIDTH*PAGE_COUNT bytes (1024 by
// default), a read fetches one byte, and newline, set cursor or string end write nothing
// to the store. After reset busy stays high while the store is swept to zero.
module text_glyph_frame_writer
  import tgfw_pkg::*;
#(
  parameter int DISPLAY_WIDTH = DISPLAY_WIDTH_DEF,
  parameter int PAGE_COUNT    = PAGE_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [7:0] char_code,
  input  wire logic [7:0] cursor_column_in,
  input  wire logic [7:0] cursor_page_in,
  input  wire logic [9:0] read_address,
  output logic            done,
  output logic      [7:0] read_data,
  output logic      [7:0] column_now,
  output logic      [2:0] page_now
);

  localparam int AW   = $clog2(DISPLAY_WIDTH * PAGE_COUNT);
  localparam int CMDW = $bits(cmd_t);
  localparam int QW   = CMDW + AW;

  logic          accept;
  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic [QW-1:0] q_data;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  cmd_t          b_cmd;
  logic [AW-1:0] b_addr;
  logic          init_busy;

  assign busy   = q_full || init_busy;
  assign accept = start && !busy;
  assign b_cmd  = cmd_t'(q_data[QW-1 -: CMDW]);
  assign b_addr = q_data[AW-1:0];

  tgfw_front #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .op              (op),
    .char_code       (char_code),
    .cursor_column_in(cursor_column_in),
    .cursor_page_in  (cursor_page_in),
    .read_address    (read_address),
    .cmd             (f_cmd),
    .addr            (f_addr)
  );

  tgfw_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({f_cmd, f_addr}),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty),
    .full     (q_full)
  );

  tgfw_back #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (b_cmd),
    .q_addr    (b_addr),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .done      (done),
    .read_data (read_data),
    .column_now(column_now),
    .page_now  (page_now)
  );

endmodule
`default_nettype wire
